@@ hw/rtl/spjg_pkg.sv @@
// Shared types, command codes, register indexes and reset values of the step pulse generator.
package spjg_pkg;

    // Command codes carried in tuser.
    localparam int CMD_W = 4;
    localparam logic [CMD_W-1:0] CMD_TICK    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_PAUSE   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_RESUME  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_CANCEL  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_ENABLE  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_DISABLE = 4'd6;
    localparam logic [CMD_W-1:0] CMD_SLEEP   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_WAKE    = 4'd8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_COUNT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_INTERVAL = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_ON       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MICROSTEP_DIV  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION      = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_CHECK    = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL   = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL   = 8'd7;

    localparam int CFG_DATA_W = 32;

    // Defaults for the module parameters.
    localparam int DEFAULT_INTERVAL_DEF = 1000;
    localparam int TIME_BITS_DEF        = 32;

    // Register reset values.
    localparam logic [31:0] RST_PULSE_COUNT    = 32'd0;
    localparam logic [31:0] RST_PULSE_INTERVAL = 32'd1000;
    localparam logic [31:0] RST_PULSE_ON       = 32'd500;
    localparam logic [7:0]  RST_MICROSTEP_DIV  = 8'd1;
    localparam logic        RST_DIRECTION      = 1'b0;
    localparam logic [31:0] RST_FAULT_CHECK    = 32'd1000000;
    localparam logic [31:0] RST_MIN_INTERVAL   = 32'd100;
    localparam logic [31:0] RST_MAX_INTERVAL   = 32'd100000;

    // Microstep pin codes.
    localparam logic [2:0] USTEP_FULL = 3'd0;
    localparam logic [2:0] USTEP_2    = 3'd1;
    localparam logic [2:0] USTEP_4    = 3'd2;
    localparam logic [2:0] USTEP_8    = 3'd3;
    localparam logic [2:0] USTEP_16   = 3'd4;
    localparam logic [2:0] USTEP_32   = 3'd5;

    // Packed widths of the stream payloads.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    typedef struct packed {
        logic [31:0] pulse_count;
        logic [31:0] step_period;
        logic [31:0] pulse_on;
        logic [7:0]  microstep_div;
        logic        direction;
        logic [31:0] fault_check;
        logic [31:0] min_interval;
        logic [31:0] max_interval;
    } cfg_t;

    typedef struct packed {
        logic       enabled;
        logic       running;
        logic       paused;
        logic       fault;
        logic       sleep;
        logic       step;
        logic       dir;
        logic       enable_pin_n;
        logic       sleep_pin_n;
        logic [2:0] code;
    } flags_t;

    typedef struct packed {
        logic [7:0]  status_flags;
        logic        step_level;
        logic        dir_level;
        logic        enable_n;
        logic        sleep_n;
        logic [2:0]  microstep_code;
        logic [31:0] pulses_left;
    } result_t;

    function automatic logic [2:0] decode_microstep(input logic [7:0] div);
        logic [2:0] code;
        unique case (div)
            8'd2:    code = USTEP_2;
            8'd4:    code = USTEP_4;
            8'd8:    code = USTEP_8;
            8'd16:   code = USTEP_16;
            8'd32:   code = USTEP_32;
            default: code = USTEP_FULL;
        endcase
        return code;
    endfunction

endpackage

@@ hw/rtl/spjg_core.sv @@
// Job state and per-command next-state logic of the step pulse generator.
module spjg_core #(
    parameter int DEFAULT_INTERVAL = spjg_pkg::DEFAULT_INTERVAL_DEF,
    parameter int TIME_BITS        = spjg_pkg::TIME_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step_en,
    input  logic [spjg_pkg::CMD_W-1:0]   cmd,
    input  logic [31:0]                  now_us,
    input  logic                         fault_active,
    input  spjg_pkg::cfg_t               cfg,
    output spjg_pkg::result_t            result
);

    localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

    // After reset every flag is low except the inactive (high) enable pin.
    localparam spjg_pkg::flags_t FLAGS_RST = '{enable_pin_n: 1'b1, default: '0};

    spjg_pkg::flags_t     flags_reg, flags_next;
    logic [TIME_BITS-1:0] next_on_reg, next_on_next;
    logic [TIME_BITS-1:0] next_off_reg, next_off_next;
    logic [TIME_BITS-1:0] last_check_reg, last_check_next;
    logic [31:0]          remaining_reg, remaining_next;
    logic [31:0]          eff_interval_reg, eff_interval_next;
    logic [31:0]          eff_on_reg, eff_on_next;

    logic [CW-1:0]        now_x;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] diff_on, diff_off, elapsed;
    logic                 due_on, due_off, check_due;
    logic [CW-1:0]        sum_on, sum_off;
    logic                 job_active;
    logic [31:0]          start_interval, start_on;

    assign now_x   = CW'(now_us);
    assign now_t   = now_x[TIME_BITS-1:0];
    assign diff_on  = now_t - next_on_reg;
    assign diff_off = now_t - next_off_reg;
    assign elapsed  = now_t - last_check_reg;
    // A time is due when it lies in the half of the wrapped range behind now.
    assign due_on    = ~diff_on[TIME_BITS-1];
    assign due_off   = ~diff_off[TIME_BITS-1];
    assign check_due = CW'(elapsed) >= CW'(cfg.fault_check);
    assign sum_on  = CW'(now_t) + CW'(eff_interval_reg);
    assign sum_off = CW'(now_t) + CW'(eff_on_reg);
    assign job_active = flags_reg.enabled & flags_reg.running & ~flags_reg.paused;

    assign start_interval = (cfg.step_period > cfg.min_interval &&
                             cfg.step_period < cfg.max_interval)
                            ? cfg.step_period : 32'(DEFAULT_INTERVAL);
    assign start_on = (cfg.pulse_on < start_interval) ? cfg.pulse_on
                                                      : {1'b0, start_interval[31:1]};

    always_comb begin
        flags_next        = flags_reg;
        next_on_next      = next_on_reg;
        next_off_next     = next_off_reg;
        last_check_next   = last_check_reg;
        remaining_next    = remaining_reg;
        eff_interval_next = eff_interval_reg;
        eff_on_next       = eff_on_reg;
        if (step_en) begin
            unique case (cmd)
                spjg_pkg::CMD_TICK: begin
                    if (job_active) begin
                        if (remaining_reg != 32'd0) begin
                            if (!flags_reg.step) begin
                                if (due_on) begin
                                    flags_next.step = 1'b1;
                                    next_off_next   = sum_off[TIME_BITS-1:0];
                                    next_on_next    = sum_on[TIME_BITS-1:0];
                                end
                            end else if (due_off) begin
                                flags_next.step = 1'b0;
                                remaining_next  = remaining_reg - 32'd1;
                            end
                        end else begin
                            flags_next.running = 1'b0;
                        end
                    end
                    if (check_due) begin
                        last_check_next = now_t;
                        if (fault_active) begin
                            flags_next.fault        = 1'b1;
                            flags_next.running      = 1'b0;
                            flags_next.enabled      = 1'b0;
                            flags_next.enable_pin_n = 1'b1;
                        end else begin
                            flags_next.fault = 1'b0;
                        end
                    end
                end
                spjg_pkg::CMD_START: begin
                    if (fault_active) begin
                        flags_next.fault        = 1'b1;
                        flags_next.running      = 1'b0;
                        flags_next.sleep        = 1'b1;
                        flags_next.sleep_pin_n  = 1'b0;
                        flags_next.enabled      = 1'b0;
                        flags_next.enable_pin_n = 1'b1;
                    end else begin
                        flags_next.fault        = 1'b0;
                        flags_next.running      = 1'b1;
                        flags_next.paused       = 1'b0;
                        flags_next.dir          = cfg.direction;
                        flags_next.code         = spjg_pkg::decode_microstep(cfg.microstep_div);
                        flags_next.step         = 1'b0;
                        flags_next.sleep_pin_n  = 1'b1;
                        flags_next.enable_pin_n = 1'b0;
                        next_on_next            = now_t;
                        eff_interval_next       = start_interval;
                        eff_on_next             = start_on;
                        remaining_next          = cfg.pulse_count;
                    end
                end
                spjg_pkg::CMD_PAUSE: begin
                    flags_next.paused = 1'b1;
                end
                spjg_pkg::CMD_RESUME: begin
                    flags_next.paused = 1'b0;
                    next_on_next      = now_t;
                end
                spjg_pkg::CMD_CANCEL: begin
                    flags_next.running = 1'b0;
                    flags_next.step    = 1'b0;
                    remaining_next     = 32'd0;
                end
                spjg_pkg::CMD_ENABLE: begin
                    flags_next.enabled      = 1'b1;
                    flags_next.enable_pin_n = 1'b0;
                end
                spjg_pkg::CMD_DISABLE: begin
                    flags_next.enabled      = 1'b0;
                    flags_next.enable_pin_n = 1'b1;
                end
                spjg_pkg::CMD_SLEEP: begin
                    flags_next.sleep       = 1'b1;
                    flags_next.sleep_pin_n = 1'b0;
                end
                spjg_pkg::CMD_WAKE: begin
                    flags_next.sleep       = 1'b0;
                    flags_next.sleep_pin_n = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg              <= FLAGS_RST;
            next_on_reg            <= '0;
            next_off_reg           <= '0;
            last_check_reg         <= '0;
            remaining_reg          <= '0;
            eff_interval_reg       <= 32'(DEFAULT_INTERVAL);
            eff_on_reg             <= 32'(DEFAULT_INTERVAL / 2);
        end else begin
            flags_reg        <= flags_next;
            next_on_reg      <= next_on_next;
            next_off_reg     <= next_off_next;
            last_check_reg   <= last_check_next;
            remaining_reg    <= remaining_next;
            eff_interval_reg <= eff_interval_next;
            eff_on_reg       <= eff_on_next;
        end
    end

    // The result reflects the state as it stands after this command.
    assign result.status_flags   = {flags_next.sleep, flags_next.running, flags_next.enabled,
                                    2'b00, flags_next.paused, flags_next.fault, flags_next.dir};
    assign result.step_level     = flags_next.step;
    assign result.dir_level      = flags_next.dir;
    assign result.enable_n       = flags_next.enable_pin_n;
    assign result.sleep_n        = flags_next.sleep_pin_n;
    assign result.microstep_code = flags_next.code;
    assign result.pulses_left    = remaining_next;

endmodule

@@ hw/rtl/stepper_pulse_job_generator_unit.sv @@
// Top level of the stepper step pulse job generator: stream ports, config registers, staging.
// Staging: an accepted command item waits in the input register; its core result is
// captured in the result register that drives m_tdata. Throughput: one command item
// per clock unless m_tready stalls the result register; the core needs a single pass of
// compares and adds. Reset: aresetn is synchronous and active low; it empties both stages
// and returns the config registers and the job state to their documented reset values.
module stepper_pulse_job_generator_unit #(
    parameter int DEFAULT_INTERVAL = spjg_pkg::DEFAULT_INTERVAL_DEF,
    parameter int TIME_BITS        = spjg_pkg::TIME_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Command stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: now_us [31:0], fault_active [32], zero pad [39:33].
    input  logic [spjg_pkg::S_TDATA_W-1:0]      s_tdata,
    // s_tuser: cmd [3:0].
    input  logic [spjg_pkg::CMD_W-1:0]          s_tuser,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: status_flags [7:0], step_level [8], dir_level [9], enable_n [10],
    // sleep_n [11], microstep_code [14:12], pulses_left [46:15], zero pad [47].
    output logic [spjg_pkg::M_TDATA_W-1:0]      m_tdata,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spjg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spjg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    spjg_pkg::cfg_t cfg_reg, cfg_next;

    logic                         in_valid_reg, in_valid_next;
    logic [spjg_pkg::CMD_W-1:0]   in_cmd_reg;
    logic [31:0]                  in_now_reg;
    logic                         in_fault_reg;
    logic                         out_valid_reg, out_valid_next;
    spjg_pkg::result_t            out_data_reg;
    spjg_pkg::result_t            core_result;

    logic s_fire;
    logic advance;

    // The configuration port never stalls; a write is registered at the next clock edge.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                spjg_pkg::REG_PULSE_COUNT:    cfg_next.pulse_count    = cfg_data;
                spjg_pkg::REG_PULSE_INTERVAL: cfg_next.step_period    = cfg_data;
                spjg_pkg::REG_PULSE_ON:       cfg_next.pulse_on       = cfg_data;
                spjg_pkg::REG_MICROSTEP_DIV:  cfg_next.microstep_div  = cfg_data[7:0];
                spjg_pkg::REG_DIRECTION:      cfg_next.direction      = cfg_data[0];
                spjg_pkg::REG_FAULT_CHECK:    cfg_next.fault_check    = cfg_data;
                spjg_pkg::REG_MIN_INTERVAL:   cfg_next.min_interval   = cfg_data;
                spjg_pkg::REG_MAX_INTERVAL:   cfg_next.max_interval   = cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The input stage hands its item to the core whenever the result register is free or
    // is being emptied in the same cycle; a new item can enter behind it at once.
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign s_fire   = s_tvalid & s_tready;

    assign in_valid_next  = s_fire | (in_valid_reg & ~advance);
    assign out_valid_next = advance | (out_valid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_count    <= spjg_pkg::RST_PULSE_COUNT;
            cfg_reg.step_period    <= spjg_pkg::RST_PULSE_INTERVAL;
            cfg_reg.pulse_on       <= spjg_pkg::RST_PULSE_ON;
            cfg_reg.microstep_div  <= spjg_pkg::RST_MICROSTEP_DIV;
            cfg_reg.direction      <= spjg_pkg::RST_DIRECTION;
            cfg_reg.fault_check    <= spjg_pkg::RST_FAULT_CHECK;
            cfg_reg.min_interval   <= spjg_pkg::RST_MIN_INTERVAL;
            cfg_reg.max_interval   <= spjg_pkg::RST_MAX_INTERVAL;
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid bits qualify them.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg   <= s_tuser;
            in_now_reg   <= s_tdata[31:0];
            in_fault_reg <= s_tdata[32];
        end
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

    spjg_core #(
        .DEFAULT_INTERVAL (DEFAULT_INTERVAL),
        .TIME_BITS        (TIME_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (advance),
        .cmd          (in_cmd_reg),
        .now_us       (in_now_reg),
        .fault_active (in_fault_reg),
        .cfg          (cfg_reg),
        .result       (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg.pulses_left, out_data_reg.microstep_code,
                       out_data_reg.sleep_n, out_data_reg.enable_n, out_data_reg.dir_level,
                       out_data_reg.step_level, out_data_reg.status_flags};

endmodule

@@ hw/rtl/spjg_checker.sv @@
// Port-level checker for the step pulse generator and its bind to the top level.
module spjg_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [spjg_pkg::M_TDATA_W-1:0]      m_tdata
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Unused status bits and the pad bit stay zero.
    a_out_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[4:3] == 2'b00 && m_tdata[47] == 1'b0)
        else $error("reserved result bits set");

    // The enabled flag is only ever set together with the active-low enable pin.
    a_enable_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> m_tdata[10] == 1'b0)
        else $error("enabled flag with enable pin inactive");

    // The direction status bit and the direction pin come from the same latch.
    a_dir_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[0] == m_tdata[9])
        else $error("direction status and pin differ");

endmodule

bind stepper_pulse_job_generator_unit spjg_checker u_spjg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/stepper_pulse_job_generator_unit_tb.sv @@
// Self-checking testbench for the stepper step pulse job generator.
`timescale 1ns / 1ps

module stepper_pulse_job_generator_unit_tb;

    // Command codes that the block must ignore while still answering.
    localparam logic [spjg_pkg::CMD_W-1:0] CMD_FIRST_UNUSED = 4'd9;
    localparam logic [spjg_pkg::CMD_W-1:0] CMD_LAST_UNUSED  = 4'd15;

    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 250;

    // One result item, laid out exactly as m_tdata[46:0], lowest field last.
    typedef struct packed {
        logic [31:0] pulses_left;
        logic [2:0]  microstep_code;
        logic        sleep_n;
        logic        enable_n;
        logic        dir_level;
        logic        step_level;
        logic [7:0]  status_flags;
    } pin_report_t;

    // Our own copy of the configuration registers.
    typedef struct {
        logic [31:0] count;
        logic [31:0] interval;
        logic [31:0] high_req;
        logic [7:0]  ustep_div;
        logic        ccw;
        logic [31:0] check_gap;
        logic [31:0] window_lo;
        logic [31:0] window_hi;
    } reg_copy_t;

    // Our own copy of the job state.
    typedef struct {
        bit          enabled;
        bit          running;
        bit          paused;
        bit          fault;
        bit          asleep;
        bit          step;
        bit          dir;
        logic [2:0]  code;
        bit          pin_en_n;
        bit          pin_sleep_n;
        logic [31:0] next_rise;
        logic [31:0] next_fall;
        logic [31:0] last_check;
        logic [31:0] left;
        logic [31:0] period;
        logic [31:0] high_time;
    } job_state_t;

    // One row of the directed part: either a register write or a command item.
    typedef struct {
        bit                             is_write;
        logic [spjg_pkg::CFG_IDX_W-1:0] idx;
        logic [31:0]                    val;
        logic [spjg_pkg::CMD_W-1:0]     cmd;
        logic [31:0]                    t;
        bit                             f;
        bit                             typed;
        pin_report_t                    want;
    } stim_row_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [spjg_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic [spjg_pkg::CMD_W-1:0]      s_tuser   = spjg_pkg::CMD_TICK;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [spjg_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [spjg_pkg::CFG_IDX_W-1:0]  cfg_index = spjg_pkg::REG_PULSE_COUNT;
    logic [spjg_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    reg_copy_t   regs;
    job_state_t  job;
    pin_report_t expected_reports[$];

    int send_gap_pct = 35;
    int recv_gap_pct = 48;
    int mismatches   = 0;
    int commands_sent   = 0;
    int reports_checked = 0;
    int pulses_stepped  = 0;
    int fault_trips     = 0;
    int settings_used   = 0;

    stepper_pulse_job_generator_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [2:0] ustep_pins(input logic [7:0] div);
        case (div)
            8'd2:    return spjg_pkg::USTEP_2;
            8'd4:    return spjg_pkg::USTEP_4;
            8'd8:    return spjg_pkg::USTEP_8;
            8'd16:   return spjg_pkg::USTEP_16;
            8'd32:   return spjg_pkg::USTEP_32;
            default: return spjg_pkg::USTEP_FULL;
        endcase
    endfunction

    // A time counts as reached when the wrapped distance to it is below half the range.
    function automatic bit reached(input logic [31:0] now_t, input logic [31:0] target);
        logic [31:0] gap;
        gap = now_t - target;
        return !gap[31];
    endfunction

    function automatic void job_reset();
        job = '{default: '0};
        job.pin_en_n    = 1'b1;
        job.pin_sleep_n = 1'b0;
        job.period      = spjg_pkg::DEFAULT_INTERVAL_DEF;
        job.high_time   = spjg_pkg::DEFAULT_INTERVAL_DEF / 2;
        regs.count     = spjg_pkg::RST_PULSE_COUNT;
        regs.interval  = spjg_pkg::RST_PULSE_INTERVAL;
        regs.high_req  = spjg_pkg::RST_PULSE_ON;
        regs.ustep_div = spjg_pkg::RST_MICROSTEP_DIV;
        regs.ccw       = spjg_pkg::RST_DIRECTION;
        regs.check_gap = spjg_pkg::RST_FAULT_CHECK;
        regs.window_lo = spjg_pkg::RST_MIN_INTERVAL;
        regs.window_hi = spjg_pkg::RST_MAX_INTERVAL;
    endfunction

    function automatic void note_register(input logic [spjg_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [31:0] val);
        case (idx)
            spjg_pkg::REG_PULSE_COUNT:    regs.count     = val;
            spjg_pkg::REG_PULSE_INTERVAL: regs.interval  = val;
            spjg_pkg::REG_PULSE_ON:       regs.high_req  = val;
            spjg_pkg::REG_MICROSTEP_DIV:  regs.ustep_div = val[7:0];
            spjg_pkg::REG_DIRECTION:      regs.ccw       = val[0];
            spjg_pkg::REG_FAULT_CHECK:    regs.check_gap = val;
            spjg_pkg::REG_MIN_INTERVAL:   regs.window_lo = val;
            spjg_pkg::REG_MAX_INTERVAL:   regs.window_hi = val;
            default: ;
        endcase
    endfunction

    // Applies one command to the job state and returns the pin report it produces.
    function automatic pin_report_t run_command(input logic [spjg_pkg::CMD_W-1:0] c,
                                                input logic [31:0] t, input bit f);
        logic [31:0] span;
        pin_report_t r;
        case (c)
            spjg_pkg::CMD_TICK: begin
                if (job.enabled && job.running && !job.paused) begin
                    if (job.left != 0) begin
                        if (!job.step) begin
                            if (reached(t, job.next_rise)) begin
                                job.step      = 1'b1;
                                job.next_fall = t + job.high_time;
                                job.next_rise = t + job.period;
                            end
                        end else if (reached(t, job.next_fall)) begin
                            job.step = 1'b0;
                            job.left = job.left - 32'd1;
                            pulses_stepped++;
                        end
                    end else begin
                        job.running = 1'b0;
                    end
                end
                // The fault line is only looked at once per check period.
                span = t - job.last_check;
                if (span >= regs.check_gap) begin
                    job.last_check = t;
                    job.fault      = f;
                    if (f) begin
                        job.running  = 1'b0;
                        job.enabled  = 1'b0;
                        job.pin_en_n = 1'b1;
                        fault_trips++;
                    end
                end
            end
            spjg_pkg::CMD_START: begin
                if (f) begin
                    job.fault       = 1'b1;
                    job.running     = 1'b0;
                    job.asleep      = 1'b1;
                    job.pin_sleep_n = 1'b0;
                    job.enabled     = 1'b0;
                    job.pin_en_n    = 1'b1;
                end else begin
                    job.fault       = 1'b0;
                    job.running     = 1'b1;
                    job.paused      = 1'b0;
                    job.dir         = regs.ccw;
                    job.code        = ustep_pins(regs.ustep_div);
                    job.step        = 1'b0;
                    job.next_rise   = t;
                    job.pin_sleep_n = 1'b1;
                    job.pin_en_n    = 1'b0;
                    // The requested period must lie strictly inside the window.
                    if (regs.interval > regs.window_lo && regs.interval < regs.window_hi)
                        job.period = regs.interval;
                    else
                        job.period = spjg_pkg::DEFAULT_INTERVAL_DEF;
                    job.high_time = (regs.high_req < job.period) ? regs.high_req
                                                                 : job.period >> 1;
                    job.left = regs.count;
                end
            end
            spjg_pkg::CMD_PAUSE:  job.paused = 1'b1;
            spjg_pkg::CMD_RESUME: begin
                job.paused    = 1'b0;
                job.next_rise = t;
            end
            spjg_pkg::CMD_CANCEL: begin
                job.running = 1'b0;
                job.step    = 1'b0;
                job.left    = '0;
            end
            spjg_pkg::CMD_ENABLE: begin
                job.enabled  = 1'b1;
                job.pin_en_n = 1'b0;
            end
            spjg_pkg::CMD_DISABLE: begin
                job.enabled  = 1'b0;
                job.pin_en_n = 1'b1;
            end
            spjg_pkg::CMD_SLEEP: begin
                job.asleep      = 1'b1;
                job.pin_sleep_n = 1'b0;
            end
            spjg_pkg::CMD_WAKE: begin
                job.asleep      = 1'b0;
                job.pin_sleep_n = 1'b1;
            end
            default: ;
        endcase
        r.status_flags   = {job.asleep, job.running, job.enabled, 2'b00,
                            job.paused, job.fault, job.dir};
        r.step_level     = job.step;
        r.dir_level      = job.dir;
        r.enable_n       = job.pin_en_n;
        r.sleep_n        = job.pin_sleep_n;
        r.microstep_code = job.code;
        r.pulses_left    = job.left;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------

    function automatic pin_report_t pins(input logic [7:0] status, input bit step_lvl,
                                         input bit dir_lvl, input bit en_n, input bit sl_n,
                                         input logic [2:0] code, input logic [31:0] left);
        pin_report_t r;
        r.status_flags   = status;
        r.step_level     = step_lvl;
        r.dir_level      = dir_lvl;
        r.enable_n       = en_n;
        r.sleep_n        = sl_n;
        r.microstep_code = code;
        r.pulses_left    = left;
        return r;
    endfunction

    function automatic stim_row_t cmd_row(input logic [spjg_pkg::CMD_W-1:0] c,
                                          input logic [31:0] t, input bit f);
        stim_row_t row;
        row       = '{default: '0};
        row.cmd   = c;
        row.t     = t;
        row.f     = f;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic [spjg_pkg::CMD_W-1:0] c,
                                            input logic [31:0] t, input bit f,
                                            input pin_report_t want);
        stim_row_t row;
        row       = cmd_row(c, t, f);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic stim_row_t write_row(input logic [spjg_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [31:0] val);
        stim_row_t row;
        row          = '{default: '0};
        row.is_write = 1'b1;
        row.idx      = idx;
        row.val      = val;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Queues the expected report, then offers the command item until it is taken.
    // tvalid is left high after acceptance so back-to-back items need no extra NBA.
    task automatic push_command(input logic [spjg_pkg::CMD_W-1:0] c, input logic [31:0] t,
                                input bit f, input bit typed, input pin_report_t want);
        pin_report_t predicted;
        predicted = run_command(c, t, f);
        expected_reports.push_back(typed ? want : predicted);
        commands_sent++;
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(spjg_pkg::S_TDATA_W-33){1'b0}}, f, t};
        s_tuser  <= c;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [spjg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        note_register(idx, val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Stops offering items and waits until every queued report has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        pin_report_t want;
        pin_report_t got;
        m_tready <= ($urandom_range(99) >= recv_gap_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                $error("result item arrived with nothing expected: 0x%0h", m_tdata);
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                got  = m_tdata[46:0];
                reports_checked++;
                check_field("status_flags", 32'(want.status_flags), 32'(got.status_flags));
                check_field("step_level", 32'(want.step_level), 32'(got.step_level));
                check_field("dir_level", 32'(want.dir_level), 32'(got.dir_level));
                check_field("enable_n", 32'(want.enable_n), 32'(got.enable_n));
                check_field("sleep_n", 32'(want.sleep_n), 32'(got.sleep_n));
                check_field("microstep_code", 32'(want.microstep_code),
                            32'(got.microstep_code));
                check_field("pulses_left", want.pulses_left, got.pulses_left);
                check_field("tdata_pad", 32'd0, 32'(m_tdata[spjg_pkg::M_TDATA_W-1]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin : stimulus
        stim_row_t                  rows[$];
        reg_copy_t                  pick;
        logic [31:0]                now_t;
        logic [spjg_pkg::CMD_W-1:0] c;
        bit                         f;
        int                         roll;
        int                         step_max;

        job_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. The job runs a two-pulse train with a period of 10 and a
        // requested high time equal to the period, so it gets halved to 5. The first
        // train starts just below the top of the time range so the rise and fall
        // straddle the wrap.
        rows.push_back(write_row(spjg_pkg::REG_PULSE_COUNT, 32'd2));
        rows.push_back(write_row(spjg_pkg::REG_PULSE_INTERVAL, 32'd10));
        rows.push_back(write_row(spjg_pkg::REG_PULSE_ON, 32'd10));
        rows.push_back(write_row(spjg_pkg::REG_MICROSTEP_DIV, 32'd32));
        rows.push_back(write_row(spjg_pkg::REG_DIRECTION, 32'd1));
        rows.push_back(write_row(spjg_pkg::REG_FAULT_CHECK, 32'hFFFF_FFFF));
        rows.push_back(write_row(spjg_pkg::REG_MIN_INTERVAL, 32'd2));
        rows.push_back(write_row(spjg_pkg::REG_MAX_INTERVAL, 32'd50));
        // An ignored code right after reset shows the reset pin levels.
        rows.push_back(typed_row(CMD_LAST_UNUSED, 32'd0, 1'b0,
                                 pins(8'h00, 1'b0, 1'b0, 1'b1, 1'b0,
                                      spjg_pkg::USTEP_FULL, 32'd0)));
        rows.push_back(typed_row(spjg_pkg::CMD_ENABLE, 32'd1, 1'b0,
                                 pins(8'h20, 1'b0, 1'b0, 1'b0, 1'b0,
                                      spjg_pkg::USTEP_FULL, 32'd0)));
        rows.push_back(typed_row(spjg_pkg::CMD_WAKE, 32'd2, 1'b0,
                                 pins(8'h20, 1'b0, 1'b0, 1'b0, 1'b1,
                                      spjg_pkg::USTEP_FULL, 32'd0)));
        // A start while the fault line is active puts the driver to sleep and disables it.
        rows.push_back(typed_row(spjg_pkg::CMD_START, 32'd3, 1'b1,
                                 pins(8'h82, 1'b0, 1'b0, 1'b1, 1'b0,
                                      spjg_pkg::USTEP_FULL, 32'd0)));
        rows.push_back(cmd_row(spjg_pkg::CMD_ENABLE, 32'd4, 1'b0));
        rows.push_back(cmd_row(spjg_pkg::CMD_WAKE, 32'd5, 1'b0));
        rows.push_back(cmd_row(spjg_pkg::CMD_START, 32'hFFFF_FFF8, 1'b0));
        rows.push_back(cmd_row(spjg_pkg::CMD_TICK, 32'hFFFF_FFF8, 1'b1));
        rows.push_back(cmd_row(spjg_pkg::CMD_TICK, 32'hFFFF_FFFC, 1'b0)); // fall not yet due
        rows.push_back(cmd_row(spjg_pkg::CMD_TICK, 32'd0, 1'b0));   // fall due across the wrap
        rows.push_back(cmd_row(spjg_pkg::CMD_PAUSE, 32'd1, 1'b0));
        rows.push_back(cmd_row(spjg_pkg::CMD_TICK, 32'd2, 1'b0));
        rows.push_back(cmd_row(spjg_pkg::CMD_RESUME, 32'd7, 1'b0));
        rows.push_back(cmd_row(spjg_pkg::CMD_TICK, 32'd7, 1'b0));
        rows.push_back(cmd_row(spjg_pkg::CMD_TICK, 32'd12, 1'b0));
        rows.push_back(cmd_row(spjg_pkg::CMD_TICK, 32'd13, 1'b0));  // count empty, job ends
        rows.push_back(cmd_row(spjg_pkg::CMD_PAUSE, 32'd14, 1'b0));
        rows.push_back(cmd_row(spjg_pkg::CMD_RESUME, 32'd15, 1'b0));
        // A period equal to the upper bound is outside the window and falls back.
        rows.push_back(write_row(spjg_pkg::REG_PULSE_INTERVAL, 32'd50));
        rows.push_back(cmd_row(spjg_pkg::CMD_START, 32'd100, 1'b0));
        rows.push_back(cmd_row(spjg_pkg::CMD_TICK, 32'd100, 1'b0));
        rows.push_back(cmd_row(spjg_pkg::CMD_CANCEL, 32'd101, 1'b0));
        rows.push_back(cmd_row(spjg_pkg::CMD_DISABLE, 32'd102, 1'b0));
        rows.push_back(cmd_row(spjg_pkg::CMD_SLEEP, 32'd103, 1'b0));
        // The check period is the full range, so only this tick triggers a fault check.
        rows.push_back(typed_row(spjg_pkg::CMD_TICK, 32'hFFFF_FFFF, 1'b1,
                                 pins(8'h83, 1'b0, 1'b1, 1'b1, 1'b0,
                                      spjg_pkg::USTEP_32, 32'd0)));
        rows.push_back(cmd_row(CMD_FIRST_UNUSED, 32'd0, 1'b1));

        settings_used = 2;
        foreach (rows[i]) begin
            if (rows[i].is_write) begin
                drain_results();
                write_reg(rows[i].idx, rows[i].val);
            end else begin
                push_command(rows[i].cmd, rows[i].t, rows[i].f, rows[i].typed, rows[i].want);
            end
        end

        // Random part. Each phase loads a fresh register setting, brings the driver up,
        // starts a job and then mostly ticks with time moving at a pace matched to the
        // pulse period, mixed with every other command, faults and time jumps.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    pick = '{default: '0};
                end
                1: begin
                    pick = '{count: 32'hFFFF_FFFF, interval: 32'hFFFF_FFFF,
                             high_req: 32'hFFFF_FFFF, ustep_div: 8'hFF, ccw: 1'b1,
                             check_gap: 32'hFFFF_FFFF, window_lo: 32'hFFFF_FFFF,
                             window_hi: 32'hFFFF_FFFF};
                end
                default: begin
                    pick.count     = $urandom_range(1, 8);
                    pick.interval  = $urandom_range(0, 64);
                    pick.high_req  = $urandom_range(0, 40);
                    case ($urandom_range(7))
                        0: pick.ustep_div = 8'd1;
                        1: pick.ustep_div = 8'd2;
                        2: pick.ustep_div = 8'd4;
                        3: pick.ustep_div = 8'd8;
                        4: pick.ustep_div = 8'd16;
                        5: pick.ustep_div = 8'd32;
                        default: pick.ustep_div = 8'($urandom_range(255));
                    endcase
                    pick.ccw       = 1'($urandom_range(1));
                    pick.check_gap = $urandom_range(0, 300);
                    pick.window_lo = $urandom_range(0, 8);
                    pick.window_hi = $urandom_range(12, 60);
                end
            endcase
            write_reg(spjg_pkg::REG_PULSE_COUNT, pick.count);
            write_reg(spjg_pkg::REG_PULSE_INTERVAL, pick.interval);
            write_reg(spjg_pkg::REG_PULSE_ON, pick.high_req);
            write_reg(spjg_pkg::REG_MICROSTEP_DIV, {24'd0, pick.ustep_div});
            write_reg(spjg_pkg::REG_DIRECTION, {31'd0, pick.ccw});
            write_reg(spjg_pkg::REG_FAULT_CHECK, pick.check_gap);
            write_reg(spjg_pkg::REG_MIN_INTERVAL, pick.window_lo);
            write_reg(spjg_pkg::REG_MAX_INTERVAL, pick.window_hi);
            settings_used++;

            // Idling: receiver-heavy first, then sender-heavy, then none at all.
            if (phase < 2) begin
                send_gap_pct = 35;
                recv_gap_pct = 48;
            end else if (phase < 4) begin
                send_gap_pct = 48;
                recv_gap_pct = 35;
            end else begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end

            now_t = (phase == 1) ? 32'hFFFF_FF00 : $urandom;
            push_command(spjg_pkg::CMD_ENABLE, now_t, 1'b0, 1'b0, '0);
            push_command(spjg_pkg::CMD_WAKE, now_t, 1'b0, 1'b0, '0);
            push_command(spjg_pkg::CMD_START, now_t, 1'b0, 1'b0, '0);

            for (int n = 3; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(99);
                if (roll < 66)      c = spjg_pkg::CMD_TICK;
                else if (roll < 72) c = spjg_pkg::CMD_START;
                else if (roll < 77) c = spjg_pkg::CMD_ENABLE;
                else if (roll < 80) c = spjg_pkg::CMD_WAKE;
                else if (roll < 84) c = spjg_pkg::CMD_PAUSE;
                else if (roll < 89) c = spjg_pkg::CMD_RESUME;
                else if (roll < 92) c = spjg_pkg::CMD_CANCEL;
                else if (roll < 94) c = spjg_pkg::CMD_DISABLE;
                else if (roll < 96) c = spjg_pkg::CMD_SLEEP;
                else c = spjg_pkg::CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
                f = ($urandom_range(99) < 4);
                // Mostly small forward steps so rises and falls come due; now and then
                // a jump anywhere in the time range.
                if ($urandom_range(99) < 2) begin
                    now_t = $urandom;
                end else begin
                    step_max = (job.period > 600) ? 300 : int'(job.period / 2) + 1;
                    now_t    = now_t + $urandom_range(0, step_max);
                end
                push_command(c, now_t, f, 1'b0, '0);
            end
        end

        drain_results();
        $display("Ran %0d command items over %0d register settings; %0d results checked.",
                 commands_sent, settings_used, reports_checked);
        $display("The model saw %0d completed step pulses and %0d fault trips.",
                 pulses_stepped, fault_trips);
        if (mismatches == 0) begin
            $display("PASS stepper_pulse_job_generator_unit");
        end else begin
            $display("FAIL stepper_pulse_job_generator_unit");
        end
        $finish;
    end

    // Watchdog: a correct run finishes in a small fraction of this.
    initial begin
        #10_000_000;
        $display("FAIL stepper_pulse_job_generator_unit");
        $finish;
    end

endmodule
